>>> rtl/core/min_window_covering_all_words_core_defines.svh
// Assertion macros for the minimum covering window core.
// No dependencies; included by files that carry concurrent checks.
`ifndef MIN_WINDOW_COVERING_ALL_WORDS_CORE_DEFINES_SVH
`define MIN_WINDOW_COVERING_ALL_WORDS_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define MWC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define MWC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mwc_pkg.sv
// Shared constants and types for the minimum covering window core.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package mwc_pkg;

  localparam int WIN_DEPTH = 1024;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int MAX_WORDS = 256;
  localparam int WORD_W    = $clog2(MAX_WORDS);
  localparam int KIND_W    = 9;
  localparam int POS_BITS  = 30;
  localparam int SPAN_W    = POS_BITS + 1;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [WORD_W-1:0]   word_id_t;
  typedef logic [SPAN_W-1:0]   span_t;
  typedef logic [KIND_W-1:0]   kinds_t;
  typedef logic [FILL_W-1:0]   cnt_t;

  localparam span_t NO_SPAN = span_t'(1) << POS_BITS;

  typedef struct packed {
    pos_t     position;
    word_id_t word_id;
  } win_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/mwc_in_if.sv
// Occurrence input channel: valid/ready plus position, word id, last flag.
// Depends on mwc_pkg.
`default_nettype none

interface mwc_in_if
  import mwc_pkg::*;
();
  logic     valid;
  logic     ready;
  pos_t     position;
  word_id_t word_id;
  logic     last_item;

  modport source (output valid, position, word_id, last_item, input ready);
  modport sink   (input valid, position, word_id, last_item, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mwc_out_if.sv
// Result output channel: valid/ready plus best span and status flags.
// Depends on mwc_pkg.
`default_nettype none

interface mwc_out_if
  import mwc_pkg::*;
();
  logic  valid;
  logic  ready;
  span_t best_span;
  logic  found;
  logic  overflow;
  logic  final_res;

  modport source (output valid, best_span, found, overflow, final_res, input ready);
  modport sink   (input valid, best_span, found, overflow, final_res, output ready);
endinterface

`default_nettype wire

>>> rtl/core/min_window_covering_all_words_core.sv
// Minimum covering window core. An accepted item goes through push, counter
// update and result register; an ignored word id goes straight to the result
// register. Each entry dropped from the left, and the oldest entry when the
// window is full, adds a read, count and write-back step. A new item is taken
// only once the last is loaded as a result; a stalled result beat holds the core.
// Reset is synchronous; counters clear at once through per-word valid bits.
`default_nettype none
`include "min_window_covering_all_words_core_defines.svh"

module min_window_covering_all_words_core
  import mwc_pkg::*;
(
  input  wire    clk,
  input  wire    rst,
  input  wire    cfg_wr_en,
  input  kinds_t cfg_wr_data,
  mwc_in_if.sink    in_ch,
  mwc_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POP_RD  = 3'd1;
  localparam logic [2:0] S_POP_CNT = 3'd2;
  localparam logic [2:0] S_POP_WB  = 3'd3;
  localparam logic [2:0] S_PUSH    = 3'd4;
  localparam logic [2:0] S_PUSH_WB = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]        state;
  logic [WIN_AW-1:0] head, tail, head_next, tail_next;
  cnt_t              fill;
  kinds_t            distinct, distinct_next;
  span_t             best;
  logic              ovf_seen;
  logic              ovf_pop;
  kinds_t            word_kinds;
  logic [MAX_WORDS-1:0] cnt_vld;

  pos_t     cur_pos;
  word_id_t cur_id;
  logic     cur_last;

  win_entry_t win_mem [WIN_DEPTH];
  win_entry_t win_q;
  cnt_t       cnt_mem [MAX_WORDS];
  cnt_t       cnt_mem_q;
  logic       cnt_vld_q;
  word_id_t   cnt_addr, cnt_rd_addr;
  cnt_t       cnt_cur, cnt_wdata;
  logic       cnt_we;

  logic   out_valid;
  span_t  out_best;
  logic   out_found, out_ovf, out_final;

  kinds_t need;
  logic   in_fire, id_ok, out_load, covered;
  pos_t   diff;
  span_t  span;

  assign need     = (word_kinds == '0) ? kinds_t'(1) : word_kinds;
  assign in_ch.ready = (state == S_IDLE) && !cfg_wr_en;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign id_ok    = kinds_t'(in_ch.word_id) < need;
  assign out_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  assign head_next = (head == WIN_AW'(WIN_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == WIN_AW'(WIN_DEPTH - 1)) ? '0 : tail + 1'b1;

  assign cnt_rd_addr = (state == S_POP_CNT) ? win_q.word_id : cur_id;
  assign cnt_cur     = cnt_vld_q ? cnt_mem_q : '0;

  always_comb begin
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_cur;
    distinct_next = distinct;
    if (state == S_POP_WB && cnt_cur != '0) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_cur - 1'b1;
      if (cnt_cur == cnt_t'(1) && distinct != '0) distinct_next = distinct - 1'b1;
    end else if (state == S_PUSH_WB) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_cur + 1'b1;
      if (cnt_cur == '0) distinct_next = distinct + 1'b1;
    end
  end

  // fill after this cycle's pop, used for the shrink loop test
  always_comb begin
    if (state == S_POP_WB) begin
      covered = (fill != cnt_t'(1)) && (distinct_next >= need);
    end else begin
      covered = (fill != '0) && (distinct_next >= need);
    end
  end

  assign diff = (cur_pos >= win_q.position) ? cur_pos - win_q.position
                                            : win_q.position - cur_pos;
  assign span = span_t'(diff) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      distinct   <= '0;
      best       <= NO_SPAN;
      ovf_seen   <= 1'b0;
      ovf_pop    <= 1'b0;
      cnt_vld    <= '0;
      word_kinds <= kinds_t'(1);
      out_valid  <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid <= 1'b0;
      if (cnt_we) cnt_vld[cnt_addr] <= 1'b1;
      distinct <= distinct_next;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (!id_ok) begin
              state <= S_DONE;
            end else if (fill == cnt_t'(WIN_DEPTH)) begin
              ovf_pop  <= 1'b1;
              ovf_seen <= 1'b1;
              state    <= S_POP_RD;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_POP_RD: begin
          state <= S_POP_CNT;
        end
        S_POP_CNT: begin
          if (!ovf_pop && span < best) best <= span;
          state <= S_POP_WB;
        end
        S_POP_WB: begin
          head <= head_next;
          fill <= fill - 1'b1;
          if (ovf_pop) begin
            ovf_pop <= 1'b0;
            state   <= S_PUSH;
          end else begin
            state <= covered ? S_POP_RD : S_DONE;
          end
        end
        S_PUSH: begin
          tail  <= tail_next;
          fill  <= fill + 1'b1;
          state <= S_PUSH_WB;
        end
        S_PUSH_WB: begin
          state <= covered ? S_POP_RD : S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (cur_last) begin
              head     <= '0;
              tail     <= '0;
              fill     <= '0;
              distinct <= '0;
              best     <= NO_SPAN;
              ovf_seen <= 1'b0;
              cnt_vld  <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // register write restarts the set
      if (cfg_wr_en) begin
        word_kinds <= cfg_wr_data;
        head       <= '0;
        tail       <= '0;
        fill       <= '0;
        distinct   <= '0;
        best       <= NO_SPAN;
        ovf_seen   <= 1'b0;
        cnt_vld    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_pos  <= in_ch.position;
      cur_id   <= in_ch.word_id;
      cur_last <= in_ch.last_item;
    end
    if (out_load) begin
      out_best  <= best;
      out_found <= best < NO_SPAN;
      out_ovf   <= ovf_seen;
      out_final <= cur_last;
    end
    cnt_addr  <= cnt_rd_addr;
    cnt_vld_q <= cnt_vld[cnt_rd_addr];
  end

  // window ring RAM
  always_ff @(posedge clk) begin
    if (state == S_PUSH) win_mem[tail] <= '{position: cur_pos, word_id: cur_id};
    if (state == S_POP_RD) win_q <= win_mem[head];
  end

  // per-word occurrence counter RAM; read every cycle, a count is only used
  // after its last write has landed
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    cnt_mem_q <= cnt_mem[cnt_rd_addr];
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.best_span = out_best;
  assign out_ch.found     = out_found;
  assign out_ch.overflow  = out_ovf;
  assign out_ch.final_res = out_final;

  `MWC_ASSERT_ALWAYS(a_distinct_le_fill, clk, rst, cnt_t'(distinct) <= fill, "distinct > fill")
  `MWC_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= cnt_t'(WIN_DEPTH), "fill beyond depth")
  `MWC_ASSERT_NEXT(a_accept_busy, clk, rst, in_fire, state != S_IDLE, "idle after accept")
  `MWC_ASSERT_IMPL(a_res_done, clk, rst, $rose(out_valid), $past(state) == S_DONE, "stray result")

endmodule

`default_nettype wire

>>> sim/mwc_window_checker.sv
// Scoreboard for the minimum covering window core: predicts each result beat
// from the occurrence beats and the word_kinds writes, then compares.
// Depends on mwc_pkg, mwc_in_if and mwc_out_if.
module mwc_window_checker
  import mwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  kinds_t      cfg_wr_data,
  mwc_in_if           in_ch,
  mwc_out_if          out_ch,
  output int unsigned results_seen,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    span_t best_span;
    logic  found;
    logic  overflow;
    logic  final_res;
  } span_report_t;

  // shadow of the window and per-word tallies
  pos_t        occ_pos  [WIN_DEPTH];
  word_id_t    occ_word [WIN_DEPTH];
  int unsigned rd_slot, wr_slot, occupancy;
  int unsigned occ_count [MAX_WORDS];
  int unsigned words_seen;
  span_t       shortest;
  logic        dropped_flag;
  kinds_t      kinds_cfg;

  span_report_t span_reports_due[$];
  int unsigned  seen_cnt = 0;
  int unsigned  err_cnt = 0;

  function automatic void clear_window();
    rd_slot      = 0;
    wr_slot      = 0;
    occupancy    = 0;
    words_seen   = 0;
    shortest     = NO_SPAN;
    dropped_flag = 1'b0;
    foreach (occ_count[i]) occ_count[i] = 0;
  endfunction

  function automatic void drop_oldest();
    word_id_t w;
    w = occ_word[rd_slot];
    if (occ_count[w] > 0) begin
      occ_count[w]--;
      if (occ_count[w] == 0 && words_seen > 0) words_seen--;
    end
    rd_slot   = (rd_slot + 1 >= WIN_DEPTH) ? 0 : rd_slot + 1;
    occupancy--;
  endfunction

  function automatic span_report_t cover_step(pos_t p, word_id_t w, logic last);
    int unsigned  need;
    pos_t         diff;
    span_t        sp;
    span_report_t r;
    need = (kinds_cfg == 0) ? 1 : int'(kinds_cfg);
    if (int'(w) < need) begin
      if (occupancy >= WIN_DEPTH) begin
        drop_oldest();
        dropped_flag = 1'b1;
      end
      occ_pos[wr_slot]  = p;
      occ_word[wr_slot] = w;
      wr_slot = (wr_slot + 1 >= WIN_DEPTH) ? 0 : wr_slot + 1;
      occupancy++;
      occ_count[w]++;
      if (occ_count[w] == 1) words_seen++;
      // shrink from the left while every word is still covered
      while (occupancy > 0 && words_seen >= need) begin
        diff = (p >= occ_pos[rd_slot]) ? p - occ_pos[rd_slot] : occ_pos[rd_slot] - p;
        sp   = span_t'(diff) + span_t'(1);
        if (sp < shortest) shortest = sp;
        drop_oldest();
      end
    end
    r.best_span = shortest;
    r.found     = (shortest < NO_SPAN);
    r.overflow  = dropped_flag;
    r.final_res = last;
    if (last) clear_window();
    return r;
  endfunction

  always @(posedge clk) begin
    span_report_t want, got;
    if (rst) begin
      kinds_cfg = kinds_t'(1);
      clear_window();
      span_reports_due.delete();
    end else begin
      if (cfg_wr_en) begin
        kinds_cfg = cfg_wr_data;
        clear_window();
      end
      if (in_ch.valid && in_ch.ready) begin
        span_reports_due = {span_reports_due,
                            cover_step(in_ch.position, in_ch.word_id, in_ch.last_item)};
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_cnt++;
        got = '{out_ch.best_span, out_ch.found, out_ch.overflow, out_ch.final_res};
        if (span_reports_due.size() == 0) begin
          $error("result beat with no prediction pending");
          err_cnt++;
        end else begin
          want = span_reports_due.pop_front();
          if (got.best_span !== want.best_span) begin
            $error("best_span: expected %0d, actual %0d", want.best_span, got.best_span);
            err_cnt++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, got.found);
            err_cnt++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
            err_cnt++;
          end
          if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0b, actual %0b", want.final_res, got.final_res);
            err_cnt++;
          end
        end
      end
    end
    results_seen <= seen_cnt;
    fail_count   <= err_cnt;
    outstanding  <= span_reports_due.size();
  end
endmodule

>>> sim/tb.sv
// Top of the covering window testbench: clock, reset, occurrence stimulus,
// random back-pressure and the verdict. Depends on mwc_pkg, the channel
// interfaces, mwc_window_checker and min_window_covering_all_words_core.
module tb
  import mwc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam pos_t        POS_TOP     = '1;

  logic   clk = 1'b0;
  logic   rst;
  logic   cfg_wr_en;
  kinds_t cfg_wr_data;

  mwc_in_if  in_ch();
  mwc_out_if out_ch();

  int unsigned results_seen, fail_count, outstanding;
  int unsigned sent;
  int unsigned src_idle, snk_idle;
  int unsigned cycle_cnt;
  kinds_t      cur_kinds;

  min_window_covering_all_words_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  mwc_window_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .results_seen (results_seen),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // valid stays high after a beat; a gap lowers it in a step of its own
  task automatic send_occ(input pos_t p, input word_id_t w, input logic last);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    in_ch.valid     <= 1'b1;
    in_ch.position  <= p;
    in_ch.word_id   <= w;
    in_ch.last_item <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != sent) @(posedge clk);
  endtask

  task automatic write_kinds(input kinds_t k);
    drain();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_kinds = k;
  endtask

  // mostly ordered sets with random content; some noise ids, some backward
  // steps, and now and then a set left open
  task automatic random_set(inout int unsigned counted);
    int unsigned lim, len;
    pos_t        p;
    word_id_t    w;
    logic        last;
    lim = (cur_kinds == 0) ? 1 : ((cur_kinds > MAX_WORDS) ? MAX_WORDS : int'(cur_kinds));
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    p   = ($urandom_range(3) == 0) ? pos_t'($urandom) : pos_t'($urandom_range(0, 2000));
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(19) == 0) p = p - pos_t'($urandom_range(1, 50));
      else p = p + pos_t'($urandom_range(0, 6));
      if ($urandom_range(99) < 85) w = word_id_t'($urandom_range(0, lim - 1));
      else w = word_id_t'($urandom_range(0, 255));
      last = (n == len - 1) && ($urandom_range(9) != 0);
      send_occ(p, w, last);
      if (int'(w) < lim) counted++;
    end
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned done, r;
    kinds_t      k;
    done = 0;
    while (done < target) begin
      r = $urandom_range(99);
      if (r < 60)      k = kinds_t'($urandom_range(1, 5));
      else if (r < 75) k = kinds_t'($urandom_range(6, 16));
      else if (r < 82) k = '0;
      else if (r < 88) k = kinds_t'(MAX_WORDS);
      else if (r < 94) k = kinds_t'($urandom_range(17, 255));
      else             k = kinds_t'($urandom_range(257, 511));
      write_kinds(k);
      repeat ($urandom_range(3, 10)) begin
        random_set(done);
        if ($urandom_range(24) == 0) drain();
      end
    end
  endtask

  // window wraps and drops entries; coverage only arrives with the final beat
  task automatic overflow_set();
    pos_t p;
    write_kinds(kinds_t'(2));
    p = pos_t'($urandom_range(0, 1000));
    repeat (WIN_DEPTH + 6) begin
      p = p + pos_t'($urandom_range(0, 3));
      send_occ(p, word_id_t'(0), 1'b0);
    end
    send_occ(p + pos_t'(1), word_id_t'(1), 1'b1);
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.position  <= '0;
    in_ch.word_id   <= '0;
    in_ch.last_item <= 1'b0;
    sent      = 0;
    src_idle  = 0;
    snk_idle  = 0;
    cur_kinds = kinds_t'(1);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one word after reset; out-of-range id ignored; extreme position
    send_occ(pos_t'(5), word_id_t'(0), 1'b0);
    send_occ(pos_t'(9), word_id_t'(1), 1'b0);
    send_occ(POS_TOP, word_id_t'(0), 1'b1);
    // zero kinds acts as one
    write_kinds('0);
    send_occ(pos_t'(7), word_id_t'(255), 1'b0);
    send_occ(pos_t'(7), word_id_t'(0), 1'b1);
    // span of 2^30 never recorded, then a one-wide span, then a backward step
    write_kinds(kinds_t'(2));
    send_occ('0, word_id_t'(0), 1'b0);
    send_occ(POS_TOP, word_id_t'(1), 1'b0);
    send_occ(POS_TOP, word_id_t'(0), 1'b0);
    send_occ(pos_t'(100), word_id_t'(1), 1'b1);
    send_occ(pos_t'(1000), word_id_t'(0), 1'b0);
    send_occ(pos_t'(990), word_id_t'(1), 1'b1);
    // all 256 words needed
    write_kinds(kinds_t'(MAX_WORDS));
    send_occ(pos_t'(3), word_id_t'(255), 1'b0);
    send_occ(pos_t'(4), word_id_t'(0), 1'b1);
    // more kinds than words exist: never covered
    write_kinds(kinds_t'(300));
    send_occ(pos_t'(11), word_id_t'(0), 1'b0);
    send_occ(pos_t'(12), word_id_t'(255), 1'b1);
    write_kinds('1);
    send_occ(pos_t'(13), word_id_t'(128), 1'b1);

    src_idle = 28;
    snk_idle = 65;
    overflow_set();

    src_idle = 65;
    snk_idle = 28;
    run_phase(40);

    src_idle = 0;
    snk_idle = 0;
    run_phase(40);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
